[rtl/assert_macros.svh]
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// overlapping implication, checked on every rising edge outside reset
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked on every rising edge outside reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/bba_pkg.sv]
package bba_pkg;

    // bitmap geometry
    localparam int NUM_BLOCKS = 32768;
    localparam int WORD_BITS  = 32;
    localparam int NUM_WORDS  = (NUM_BLOCKS + WORD_BITS - 1) / WORD_BITS;
    localparam int BIT_W      = $clog2(WORD_BITS);
    localparam int WADDR_W    = $clog2(NUM_WORDS);

    // field widths
    localparam int ID_W      = 15;
    localparam int LIM_W     = 16;
    localparam int SCAN_W    = LIM_W - BIT_W;
    localparam int STATUS_W  = 2;
    localparam int CFG_IDX_W = 4;
    localparam int CFG_DAT_W = 16;
    localparam int ID_SPACE  = 32768;

    // block count can never exceed the bitmap or the id space
    localparam logic [LIM_W-1:0] LIMIT_CAP =
        LIM_W'((NUM_BLOCKS < ID_SPACE) ? NUM_BLOCKS : ID_SPACE);

    // register reset values
    localparam logic [LIM_W-1:0] TOTAL_BLOCKS_RST = LIM_W'(32768);
    localparam logic [ID_W-1:0]  FIRST_ALLOC_RST  = ID_W'(4096);

    // request codes
    localparam logic FUNC_ALLOC = 1'b0;
    localparam logic FUNC_FREE  = 1'b1;

    // status codes
    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_BLOCKS = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_ALLOC  = 4'd1;

    // settings seen by the allocator core
    typedef struct packed {
        logic [LIM_W-1:0] limit;
        logic [ID_W-1:0]  first_alloc;
    } bba_cfg_t;

    // one result item
    typedef struct packed {
        logic [ID_W-1:0]     alloc_id;
        logic [STATUS_W-1:0] status;
    } bba_rsp_t;

endpackage

[rtl/bba_if.sv]
// request channel
interface bba_req_if import bba_pkg::*; ();
    logic            valid;
    logic            ready;
    logic            func;
    logic [ID_W-1:0] block_id;

    modport source (output valid, output func, output block_id, input ready);
    modport sink   (input valid, input func, input block_id, output ready);
endinterface

// result channel
interface bba_rsp_if import bba_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [ID_W-1:0]     alloc_id;
    logic [STATUS_W-1:0] status;

    modport source (output valid, output alloc_id, output status, input ready);
    modport sink   (input valid, input alloc_id, input status, output ready);
endinterface

// register write channel
interface bba_cfg_if import bba_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_DAT_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

[rtl/bba_core.sv]
module bba_core import bba_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  bba_cfg_t        cfg,
    input  logic            req_valid,
    output logic            req_ready,
    input  logic            req_func,
    input  logic [ID_W-1:0] req_block_id,
    output logic            rsp_valid,
    input  logic            rsp_ready,
    output bba_rsp_t        rsp
);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_FREE_RD,
        ST_FREE_WR,
        ST_SCAN_RD,
        ST_SCAN,
        ST_DONE
    } state_t;

    state_t              state_reg, state_next;
    logic [WADDR_W-1:0]  clr_ptr_reg, clr_ptr_next;
    logic [ID_W-1:0]     id_reg, id_next;
    logic [SCAN_W-1:0]   chk_ptr_reg, chk_ptr_next;
    bba_rsp_t            res_reg, res_next;
    logic                rsp_valid_reg, rsp_valid_next;
    bba_rsp_t            rsp_reg, rsp_next;

    // bitmap memory, one read and one write port
    logic [WORD_BITS-1:0] mem [NUM_WORDS];
    logic [WORD_BITS-1:0] rd_data_reg;
    logic                 mem_we;
    logic [WADDR_W-1:0]   mem_waddr;
    logic [WORD_BITS-1:0] mem_wdata;
    logic                 mem_re;
    logic [WADDR_W-1:0]   mem_raddr;

    // scan bounds
    logic [LIM_W-1:0]     lim_m1;
    logic [SCAN_W-1:0]    first_word;
    logic [SCAN_W-1:0]    last_word;
    logic                 none_allocatable;
    logic [WORD_BITS-1:0] cand;
    logic                 found;
    logic [BIT_W-1:0]     found_bit;
    logic [WORD_BITS-1:0] id_mask;
    logic                 out_free;

    assign lim_m1           = cfg.limit - 1'b1;
    assign first_word       = SCAN_W'(cfg.first_alloc >> BIT_W);
    assign last_word        = SCAN_W'(lim_m1 >> BIT_W);
    assign none_allocatable = (cfg.limit <= LIM_W'(cfg.first_alloc));
    assign id_mask          = WORD_BITS'(1) << id_reg[BIT_W-1:0];
    assign out_free         = !rsp_valid_reg || rsp_ready;

    // free candidates in the word under check, trimmed at both scan ends
    always_comb
    begin
        for (int i = 0; i < WORD_BITS; i++)
        begin
            cand[i] = !rd_data_reg[i]
                && ((chk_ptr_reg != first_word)
                    || (BIT_W'(i) >= cfg.first_alloc[BIT_W-1:0]))
                && ((chk_ptr_reg != last_word)
                    || (BIT_W'(i) <= lim_m1[BIT_W-1:0]));
        end
    end

    // lowest free candidate
    always_comb
    begin
        found     = 1'b0;
        found_bit = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--)
        begin
            if (cand[i])
            begin
                found     = 1'b1;
                found_bit = BIT_W'(i);
            end
        end
    end

    // control and memory port steering
    always_comb
    begin
        state_next     = state_reg;
        clr_ptr_next   = clr_ptr_reg;
        id_next        = id_reg;
        chk_ptr_next   = chk_ptr_reg;
        res_next       = res_reg;
        rsp_valid_next = rsp_valid_reg;
        rsp_next       = rsp_reg;
        mem_we         = 1'b0;
        mem_waddr      = WADDR_W'(id_reg >> BIT_W);
        mem_wdata      = '0;
        mem_re         = 1'b0;
        mem_raddr      = WADDR_W'(id_reg >> BIT_W);
        req_ready      = 1'b0;

        if (rsp_valid_reg && rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end

        case (state_reg)
            ST_CLEAR:
            begin
                mem_we       = 1'b1;
                mem_waddr    = clr_ptr_reg;
                mem_wdata    = '0;
                clr_ptr_next = clr_ptr_reg + 1'b1;
                if (clr_ptr_reg == WADDR_W'(NUM_WORDS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    id_next  = req_block_id;
                    res_next = '{alloc_id: '0, status: STATUS_OK};
                    if (req_func == FUNC_FREE)
                    begin
                        if (LIM_W'(req_block_id) >= cfg.limit)
                        begin
                            res_next.status = STATUS_RANGE;
                            state_next      = ST_DONE;
                        end
                        else
                        begin
                            state_next = ST_FREE_RD;
                        end
                    end
                    else if (none_allocatable)
                    begin
                        res_next.status = STATUS_FULL;
                        state_next      = ST_DONE;
                    end
                    else
                    begin
                        state_next = ST_SCAN_RD;
                    end
                end
            end
            ST_FREE_RD:
            begin
                mem_re     = 1'b1;
                state_next = ST_FREE_WR;
            end
            ST_FREE_WR:
            begin
                mem_we     = 1'b1;
                mem_wdata  = rd_data_reg & ~id_mask;
                state_next = ST_DONE;
            end
            ST_SCAN_RD:
            begin
                mem_re       = 1'b1;
                mem_raddr    = WADDR_W'(first_word);
                chk_ptr_next = first_word;
                state_next   = ST_SCAN;
            end
            ST_SCAN:
            begin
                // check the word in hand while the next one is read
                if (found)
                begin
                    mem_we           = 1'b1;
                    mem_waddr        = WADDR_W'(chk_ptr_reg);
                    mem_wdata        = rd_data_reg | (WORD_BITS'(1) << found_bit);
                    res_next.alloc_id = ID_W'({chk_ptr_reg, found_bit});
                    res_next.status  = STATUS_OK;
                    state_next       = ST_DONE;
                end
                else if (chk_ptr_reg == last_word)
                begin
                    res_next.status = STATUS_FULL;
                    state_next      = ST_DONE;
                end
                else
                begin
                    mem_re       = 1'b1;
                    mem_raddr    = WADDR_W'(chk_ptr_reg + 1'b1);
                    chk_ptr_next = chk_ptr_reg + 1'b1;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    rsp_valid_next = 1'b1;
                    rsp_next       = res_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_ptr_reg   <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_ptr_reg   <= clr_ptr_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        id_reg      <= id_next;
        chk_ptr_reg <= chk_ptr_next;
        res_reg     <= res_next;
        rsp_reg     <= rsp_next;
    end

    // bitmap write port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
    end

    // bitmap read port
    always_ff @(posedge clk)
    begin
        if (mem_re)
        begin
            rd_data_reg <= mem[mem_raddr];
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

[rtl/block_bitmap_allocator_top.sv]
// First-fit block allocator over a used/free bitmap held in one 1024 x 32 memory.
// After reset the block clears the bitmap, one word a cycle over all 1024 words,
// and takes no request until that is done; register writes are taken at any time.
// A free reads the word holding the block, clears its bit and writes the word back,
// then posts the result. An allocate reads bitmap words from the word holding
// first_allocatable up to the word with the first free block and sets that bit.
// The scan speed is set by the single read port of the bitmap memory, one word per
// cycle. Requests are handled one at a time; the result sits in an output register,
// so the next request can be taken while the previous result waits for its transfer.
module block_bitmap_allocator_top import bba_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    bba_req_if.sink   req,
    bba_rsp_if.source rsp,
    bba_cfg_if.sink   cfg
);

    logic [LIM_W-1:0] total_blocks_reg, total_blocks_next;
    logic [ID_W-1:0]  first_alloc_reg, first_alloc_next;
    bba_cfg_t         core_cfg;
    bba_rsp_t         core_rsp;

    // register writes are always taken
    assign cfg.ready = 1'b1;

    always_comb
    begin
        total_blocks_next = total_blocks_reg;
        first_alloc_next  = first_alloc_reg;
        if (cfg.valid)
        begin
            case (cfg.index)
                CFG_TOTAL_BLOCKS: total_blocks_next = LIM_W'(cfg.data);
                CFG_FIRST_ALLOC:  first_alloc_next  = cfg.data[ID_W-1:0];
                default:          ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_blocks_reg <= TOTAL_BLOCKS_RST;
            first_alloc_reg  <= FIRST_ALLOC_RST;
        end
        else
        begin
            total_blocks_reg <= total_blocks_next;
            first_alloc_reg  <= first_alloc_next;
        end
    end

    // effective block count
    assign core_cfg.limit       = (total_blocks_reg < LIMIT_CAP) ? total_blocks_reg
                                                                 : LIMIT_CAP;
    assign core_cfg.first_alloc = first_alloc_reg;

    bba_core u_core
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (core_cfg),
        .req_valid    (req.valid),
        .req_ready    (req.ready),
        .req_func     (req.func),
        .req_block_id (req.block_id),
        .rsp_valid    (rsp.valid),
        .rsp_ready    (rsp.ready),
        .rsp          (core_rsp)
    );

    assign rsp.alloc_id = core_rsp.alloc_id;
    assign rsp.status   = core_rsp.status;

endmodule

[rtl/bba_checker.sv]
`include "assert_macros.svh"

module bba_checker import bba_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                req_valid,
    input logic                req_ready,
    input logic                rsp_valid,
    input logic                rsp_ready,
    input logic [ID_W-1:0]     rsp_alloc_id,
    input logic [STATUS_W-1:0] rsp_status
);

    logic [1:0] pending_reg, pending_next;
    logic       req_xfer;
    logic       rsp_xfer;

    assign req_xfer = req_valid && req_ready;
    assign rsp_xfer = rsp_valid && rsp_ready;

    // requests taken but not yet answered
    always_comb
    begin
        pending_next = pending_reg;
        if (req_xfer && !rsp_xfer)
        begin
            pending_next = pending_reg + 1'b1;
        end
        else if (!req_xfer && rsp_xfer)
        begin
            pending_next = pending_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else
        begin
            pending_reg <= pending_next;
        end
    end

    `ASSERT_IMPLIES(a_rsp_has_req, clk, rst_n, rsp_valid, pending_reg != 2'd0, "result without request")
    `ASSERT_IMPLIES(a_one_in_work, clk, rst_n, 1'b1, pending_reg <= 2'd2, "too many requests in flight")
    `ASSERT_IMPLIES(a_fail_zero_id, clk, rst_n, rsp_valid && (rsp_status != STATUS_OK), rsp_alloc_id == '0, "failed result with nonzero id")
    `ASSERT_NEXT(a_rsp_hold, clk, rst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_alloc_id) && $stable(rsp_status), "stalled result changed")

endmodule

bind block_bitmap_allocator_top bba_checker u_bba_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .req_valid    (req.valid),
    .req_ready    (req.ready),
    .rsp_valid    (rsp.valid),
    .rsp_ready    (rsp.ready),
    .rsp_alloc_id (rsp.alloc_id),
    .rsp_status   (rsp.status)
);
